// ===== src/chu_pkg.sv =====
// Shared types, constants and filter arithmetic for the chroma horizontal upsampler.
package chu_pkg;

	localparam int SAMPLE_BITS = 8;
	localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int MAX_RES     = 4;
	localparam int CNT_W       = 3;
	localparam int FACTOR_W    = 3;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [FACTOR_W-1:0] factor;
		logic                fancy;
	} cfg_t;

	typedef struct packed {
		logic [MAX_RES-1:0][SAMPLE_BITS-1:0] smp;
		logic [MAX_RES-1:0]                  row_end;
		cnt_t                                cnt;
	} res_t;

	// (3c + p + 1) >> 2
	function automatic sample_t tri_left(input sample_t c, input sample_t p);
		logic [SAMPLE_BITS+1:0] sum;
		sum = ({2'b00, c} << 1) + {2'b00, c} + {2'b00, p} + (SAMPLE_BITS+2)'(1);
		return sum[SAMPLE_BITS+1:2];
	endfunction

	// (3c + n + 2) >> 2
	function automatic sample_t tri_right(input sample_t c, input sample_t n);
		logic [SAMPLE_BITS+1:0] sum;
		sum = ({2'b00, c} << 1) + {2'b00, c} + {2'b00, n} + (SAMPLE_BITS+2)'(2);
		return sum[SAMPLE_BITS+1:2];
	endfunction

endpackage

// ===== src/chu_regs.sv =====
// APB configuration registers: horizontal factor and fancy enable.
module chu_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [chu_pkg::APB_AW-1:0]  paddr,
	input  logic [chu_pkg::APB_DW-1:0]  pwdata,
	output logic [chu_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output chu_pkg::cfg_t               cfg,
	output logic                        cfg_wr
);

	localparam logic REG_FACTOR = 1'b0;
	localparam logic REG_FANCY  = 1'b1;

	logic       reg_idx;
	logic [2:0] factor_q;
	logic       fancy_q;

	// Registers sit at byte offsets 0 and 4; the word index is address bit 2
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= 3'd2;
			fancy_q  <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_FACTOR: factor_q <= pwdata[2:0];
				REG_FANCY:  fancy_q  <= pwdata[0];
				default:    factor_q <= factor_q;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_FACTOR: prdata = {{(chu_pkg::APB_DW-3){1'b0}}, factor_q};
			REG_FANCY:  prdata = {{(chu_pkg::APB_DW-1){1'b0}}, fancy_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.factor = factor_q;
	assign cfg.fancy  = fancy_q;

endmodule

// ===== src/chu_filter.sv =====
// Replication / triangle filter with held-sample state; builds up to four results per word.
module chu_filter (
	input  logic             clk,
	input  logic             arst_n,
	input  chu_pkg::cfg_t    cfg,
	input  logic             cfg_wr,
	input  logic             step,
	input  chu_pkg::sample_t in_sample,
	input  logic             row_end,
	output chu_pkg::res_t    res
);

	chu_pkg::sample_t left_q;
	chu_pkg::sample_t held_q;
	logic             held_valid_q;
	logic             held_first_q;

	chu_pkg::cnt_t    f;
	logic             fancy_mode;

	// Clamp the factor to 1..4
	always_comb begin
		if (cfg.factor == 3'd0)
			f = chu_pkg::cnt_t'(1);
		else if (cfg.factor > 3'd4)
			f = chu_pkg::cnt_t'(4);
		else
			f = chu_pkg::cnt_t'(cfg.factor);
	end

	assign fancy_mode = (f == chu_pkg::cnt_t'(2)) && cfg.fancy;

	// Build the result set for the word in the input register
	always_comb begin
		res = '0;
		if (fancy_mode) begin
			if (!held_valid_q) begin
				if (row_end) begin
					res.smp[0]     = in_sample;
					res.smp[1]     = in_sample;
					res.row_end[1] = 1'b1;
					res.cnt        = chu_pkg::cnt_t'(2);
				end
			end else begin
				res.smp[0] = held_first_q ? held_q : chu_pkg::tri_left(held_q, left_q);
				res.smp[1] = chu_pkg::tri_right(held_q, in_sample);
				if (row_end) begin
					res.smp[2]     = chu_pkg::tri_left(in_sample, held_q);
					res.smp[3]     = in_sample;
					res.row_end[3] = 1'b1;
					res.cnt        = chu_pkg::cnt_t'(4);
				end else begin
					res.cnt = chu_pkg::cnt_t'(2);
				end
			end
		end else begin
			for (int i = 0; i < chu_pkg::MAX_RES; i++) begin
				res.smp[i]     = in_sample;
				res.row_end[i] = row_end && (chu_pkg::cnt_t'(i) + chu_pkg::cnt_t'(1) == f);
			end
			res.cnt = f;
		end
	end

	// Advance held-sample state; a config write drops whatever is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			held_first_q <= 1'b1;
		end else if (cfg_wr) begin
			held_valid_q <= 1'b0;
			held_first_q <= 1'b1;
		end else if (step) begin
			if (fancy_mode) begin
				if (!held_valid_q) begin
					held_first_q <= 1'b1;
					if (!row_end) begin
						held_q       <= in_sample;
						held_valid_q <= 1'b1;
					end
				end else if (row_end) begin
					held_valid_q <= 1'b0;
					held_first_q <= 1'b1;
				end else begin
					left_q       <= held_q;
					held_q       <= in_sample;
					held_first_q <= 1'b0;
				end
			end else begin
				held_valid_q <= 1'b0;
				held_first_q <= 1'b1;
			end
		end
	end

	// A sample is held only while the triangle filter is selected
	a_held_only_fancy: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> fancy_mode)
		else $error("held sample outside fancy mode");

	// A replicated word leaves nothing held
	a_repl_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && !fancy_mode |=> !held_valid_q)
		else $error("held sample survives a replicated word");

endmodule

// ===== src/chu_serializer.sv =====
// Output buffer: takes a result set of up to four words and sends one word per cycle while m_tready is high.
module chu_serializer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  chu_pkg::res_t                 res,
	output logic                          load_ok,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [chu_pkg::TDATA_W-1:0]   m_tdata,
	output logic                          m_tlast,
	output logic                          m_tuser
);

	logic [chu_pkg::MAX_RES-1:0][chu_pkg::SAMPLE_BITS-1:0] smp_q;
	logic [chu_pkg::MAX_RES-1:0]                           re_q;
	chu_pkg::cnt_t                                         cnt_q;
	logic                                                  pop;

	assign m_tvalid = (cnt_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign load_ok  = (cnt_q == '0) || ((cnt_q == chu_pkg::cnt_t'(1)) && m_tready);

	// Head of the buffer drives the port
	assign m_tdata = chu_pkg::TDATA_W'(smp_q[0]);
	assign m_tlast = re_q[0];
	assign m_tuser = (cnt_q == chu_pkg::cnt_t'(1));

	// Load a new set, or shift down on each word taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - chu_pkg::cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			smp_q <= res.smp;
			re_q  <= res.row_end;
		end else if (pop) begin
			for (int i = 0; i < chu_pkg::MAX_RES - 1; i++) begin
				smp_q[i] <= smp_q[i+1];
				re_q[i]  <= re_q[i+1];
			end
		end
	end

	// Never more words than one set can hold
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= chu_pkg::cnt_t'(chu_pkg::MAX_RES))
		else $error("buffer count out of range");

	// A load never overwrites words still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == '0) || (cnt_q == chu_pkg::cnt_t'(1) && pop))
		else $error("result set overwritten");

endmodule

// ===== src/chroma_horizontal_upsampler_core.sv =====
// Top level of the chroma horizontal upsampler.
//
// Usage: component samples enter on the s_ stream, one per word, with
// s_tlast on the last sample of each row. Each row leaves on the m_ stream
// widened by the horizontal factor (1 to 4). With factor 2 and fancy mode on,
// a triangle filter replaces replication; one sample is then held until its
// right neighbour arrives, so a word gives 0, 2 or 4 output words, the row's
// last word giving four unless it is alone in its row. m_tlast marks the last word of a row, m_tuser the
// last word caused by one input word.
// A word accepted on s_ waits in the input register until it moves on into
// the output buffer, which sends one output word per cycle while m_tready is
// high; an input word moves on in a cycle where the output buffer is empty or
// its final word is being taken.
// Configuration goes through the APB port at offsets 0 (factor) and 4
// (fancy); any write drops a held sample and starts a new row.
// Reset clears the input register, the output buffer and the held sample.
// When the receiver stalls, the buffered words wait and the input register
// fills, after which s_tready drops.
module chroma_horizontal_upsampler_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_tdata: in_sample
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [chu_pkg::TDATA_W-1:0]   s_tdata,
	input  logic                          s_tlast,
	// m_tdata: out_sample
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [chu_pkg::TDATA_W-1:0]   m_tdata,
	output logic                          m_tlast,
	// m_tuser: last_of_run
	output logic                          m_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [chu_pkg::APB_AW-1:0]    paddr,
	input  logic [chu_pkg::APB_DW-1:0]    pwdata,
	output logic [chu_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	chu_pkg::cfg_t    cfg;
	logic             cfg_wr;
	chu_pkg::res_t    res;
	logic             load_ok;
	logic             step;
	logic             vld_s1;
	chu_pkg::sample_t smp_s1;
	logic             re_s1;

	chu_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.cfg_wr  (cfg_wr)
	);

	// Input register
	assign step     = vld_s1 && load_ok;
	assign s_tready = !vld_s1 || load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			vld_s1 <= 1'b1;
		end else if (step) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			smp_s1 <= s_tdata[chu_pkg::SAMPLE_BITS-1:0];
			re_s1  <= s_tlast;
		end
	end

	chu_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cfg_wr    (cfg_wr),
		.step      (step),
		.in_sample (smp_s1),
		.row_end   (re_s1),
		.res       (res)
	);

	chu_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.res      (res),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// A word that yields results shows one on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		step && (res.cnt != '0) |=> m_tvalid)
		else $error("result set lost");

endmodule

// ===== test/tb_chroma_horizontal_upsampler_core.sv =====
// Self-checking testbench for the chroma horizontal upsampler core.
module tb_chroma_horizontal_upsampler_core;

	localparam logic [chu_pkg::APB_AW-1:0] FACTOR_ADDR = chu_pkg::APB_AW'(0);
	localparam logic [chu_pkg::APB_AW-1:0] FANCY_ADDR  = chu_pkg::APB_AW'(4);
	localparam int PHASES      = 12;
	localparam int PHASE_WORDS = 36;
	localparam int IDLE_PCT    = 29;
	localparam int SETTLE_CYC  = 8;
	localparam int HOLD_CYC    = 160;
	localparam int LIMIT       = 400000;

	typedef struct {
		chu_pkg::sample_t smp;
		bit               last;
	} in_word_t;

	typedef struct {
		chu_pkg::sample_t smp;
		bit               row_end;
		bit               run_end;
	} out_word_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [chu_pkg::TDATA_W-1:0]   s_tdata = '0;
	logic                          s_tlast = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [chu_pkg::TDATA_W-1:0]   m_tdata;
	logic                          m_tlast;
	logic                          m_tuser;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [chu_pkg::APB_AW-1:0]    paddr = '0;
	logic [chu_pkg::APB_DW-1:0]    pwdata = '0;
	logic [chu_pkg::APB_DW-1:0]    prdata;
	logic                          pready;

	// stimulus and expected output words
	in_word_t  feed_words[$];
	out_word_t due_words[$];
	in_word_t  drv_word;

	// upsampler state mirror, reset values
	logic [chu_pkg::FACTOR_W-1:0] factor_reg = chu_pkg::FACTOR_W'(2);
	bit                           fancy_reg = 1'b1;
	chu_pkg::sample_t             prev_smp = '0;
	chu_pkg::sample_t             held_smp = '0;
	bit                           held_ok = 1'b0;
	bit                           held_first = 1'b1;

	int  fails = 0;
	int  hold_words = 0;
	int  hold_left = 0;
	int  cycles = 0;
	bit  calm = 1'b0;

	chroma_horizontal_upsampler_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// (3c + p + 1) >> 2 and (3c + n + 2) >> 2 in 10-bit arithmetic
	function automatic chu_pkg::sample_t tri_blend(chu_pkg::sample_t c,
		chu_pkg::sample_t side, int rnd);
		logic [chu_pkg::SAMPLE_BITS+1:0] acc;
		acc = (chu_pkg::SAMPLE_BITS+2)'(3) * {2'b00, c} + {2'b00, side}
			+ (chu_pkg::SAMPLE_BITS+2)'(rnd);
		return acc[chu_pkg::SAMPLE_BITS+1:2];
	endfunction

	function automatic void queue_out(chu_pkg::sample_t s, bit re);
		out_word_t w;
		w.smp = s;
		w.row_end = re;
		w.run_end = 1'b0;
		due_words.push_back(w);
	endfunction

	// predict the output words that one accepted sample releases
	function automatic void widen_sample(chu_pkg::sample_t x, bit re);
		int               f;
		int               n0;
		chu_pkg::sample_t h;
		n0 = due_words.size();
		f = (factor_reg == 0) ? 1 : ((factor_reg > 4) ? 4 : int'(factor_reg));
		if (f == 2 && fancy_reg) begin
			if (!held_ok) begin
				if (re) begin
					// lone sample in a row: plain replication
					queue_out(x, 1'b0);
					queue_out(x, 1'b1);
				end else begin
					held_smp = x;
					held_ok = 1'b1;
				end
				held_first = 1'b1;
			end else begin
				h = held_smp;
				queue_out(held_first ? h : tri_blend(h, prev_smp, 1), 1'b0);
				queue_out(tri_blend(h, x, 2), 1'b0);
				if (re) begin
					queue_out(tri_blend(x, h, 1), 1'b0);
					queue_out(x, 1'b1);
					held_ok = 1'b0;
					held_first = 1'b1;
				end else begin
					prev_smp = h;
					held_smp = x;
					held_first = 1'b0;
				end
			end
		end else begin
			for (int i = 0; i < f; i++)
				queue_out(x, re && (i == f - 1));
			held_ok = 1'b0;
			held_first = 1'b1;
		end
		if (due_words.size() > n0)
			due_words[$].run_end = 1'b1;
	endfunction

	// driver: predict on acceptance, then offer the next word or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				widen_sample(drv_word.smp, drv_word.last);
			if (!s_tvalid || s_tready) begin
				if (feed_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					drv_word = feed_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= drv_word.smp;
					s_tlast <= drv_word.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// back-pressure: count taken words and stall long enough for the core to fill up
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (m_tvalid && m_tready) begin
			hold_words <= hold_words + 1;
			if (hold_words % 500 == 249)
				hold_left <= HOLD_CYC;
		end
	end

	// monitor: check each output word, then choose ready for the next cycle
	always @(posedge clk) begin
		out_word_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_words.size() == 0) begin
					$error("unexpected output word: sample %0d tlast %0b tuser %0b",
						m_tdata, m_tlast, m_tuser);
					fails++;
				end else begin
					want = due_words.pop_front();
					if (m_tdata !== want.smp) begin
						$error("out_sample: expected %0d, got %0d", want.smp, m_tdata);
						fails++;
					end
					if (m_tlast !== want.row_end) begin
						$error("out_row_end: expected %0b, got %0b", want.row_end, m_tlast);
						fails++;
					end
					if (m_tuser !== want.run_end) begin
						$error("last_of_run: expected %0b, got %0b", want.run_end, m_tuser);
						fails++;
					end
				end
			end
			if (hold_left != 0)
				m_tready <= 1'b0;
			else
				m_tready <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("** chroma_horizontal_upsampler_core: FAILED **");
			$finish;
		end
	end

	function automatic void push_word(chu_pkg::sample_t s, bit last);
		in_word_t w;
		w.smp = s;
		w.last = last;
		feed_words.push_back(w);
	endfunction

	// wait until all words are out, plus slack for a sample still held
	task automatic settle();
		while (feed_words.size() != 0 || s_tvalid || due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic apb_write(logic [chu_pkg::APB_AW-1:0] addr,
		logic [chu_pkg::APB_DW-1:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// any write drops the held sample and restarts the row
		if (addr == FACTOR_ADDR)
			factor_reg = data[chu_pkg::FACTOR_W-1:0];
		else
			fancy_reg = data[0];
		held_ok = 1'b0;
		held_first = 1'b1;
		// let the bus go idle before it can be taken again
		@(posedge clk);
	endtask

	initial begin
		int               fct[PHASES];
		int               fcy[PHASES];
		int               calm_ph;
		int               cnt;
		int               len;
		chu_pkg::sample_t s;
		fct = '{2, 0, 1, 2, 3, 4, 2, 5, 7, 2, 2, 2};
		fcy = '{1, 1, 0, 0, 1, 0, 1, 1, 0, 1, 1, 1};
		calm_ph = $urandom_range(PHASES - 1);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: lone samples, extremes through the filter, then a held sample
		push_word(8'h00, 1'b1);
		push_word(8'hFF, 1'b1);
		push_word(8'hFF, 1'b0);
		push_word(8'h00, 1'b1);
		push_word(8'h00, 1'b0);
		push_word(8'hFF, 1'b0);
		push_word(8'h00, 1'b0);
		push_word(8'hFF, 1'b1);
		push_word(8'hAA, 1'b0);
		push_word(8'h55, 1'b0);
		push_word(8'h80, 1'b0);
		push_word(8'h7F, 1'b0);
		push_word(8'h01, 1'b1);
		push_word(8'hFF, 1'b0);
		push_word(8'hFF, 1'b0);
		push_word(8'hFF, 1'b1);
		push_word(8'h3C, 1'b0);

		// random rows under a sweep of settings; a phase may end mid-row
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			calm = (ph == calm_ph);
			apb_write(FACTOR_ADDR, ($urandom << chu_pkg::FACTOR_W)
				| chu_pkg::APB_DW'(fct[ph]));
			apb_write(FANCY_ADDR, ($urandom << 1) | chu_pkg::APB_DW'(fcy[ph]));
			cnt = 0;
			while (cnt < PHASE_WORDS) begin
				len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
				for (int k = 0; k < len && cnt < PHASE_WORDS; k++) begin
					if ($urandom_range(3) == 0)
						s = $urandom_range(1) ? 8'hFF : 8'h00;
					else
						s = chu_pkg::sample_t'($urandom_range(255));
					push_word(s, k == len - 1);
					cnt++;
				end
			end
		end

		settle();
		calm = 1'b0;
		if (fails == 0)
			$display("** chroma_horizontal_upsampler_core: PASSED **");
		else
			$display("** chroma_horizontal_upsampler_core: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
src/chu_pkg.sv
src/chu_regs.sv
src/chu_filter.sv
src/chu_serializer.sv
src/chroma_horizontal_upsampler_core.sv
test/tb_chroma_horizontal_upsampler_core.sv
